// File: design/alu_with_flags_32bit_unit_assert.svh
// ----------------------------------------------------------------------------
// alu assertion macros
// shared concurrent assertion forms for the alu block
// ----------------------------------------------------------------------------
`ifndef ALU_WITH_FLAGS_32BIT_UNIT_ASSERT_SVH
`define ALU_WITH_FLAGS_32BIT_UNIT_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define ALU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alu assertion failed");

// consequent holds in the cycle after the antecedent
`define ALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alu assertion failed");

`endif

// File: design/alu32_pkg.sv
// ----------------------------------------------------------------------------
// alu32 package
// widths, operation codes and the result bundle of the 32-bit alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package alu32_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 4;
    localparam int SHAMT_W = 5;
    localparam int WIDE_W  = 2 * DATA_W;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_AND = 4'd2,
        OP_OR  = 4'd3,
        OP_XOR = 4'd4,
        OP_NOT = 4'd5,
        OP_SHL = 4'd6,
        OP_SHR = 4'd7,
        OP_ROL = 4'd8,
        OP_ROR = 4'd9
    } t_alu_op;

    // result value with its flags
    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              zero_flag;
        logic              negative_flag;
        logic              carry_flag;
        logic              overflow_flag;
    } t_alu_result;

endpackage

// File: design/alu32_if.sv
// ----------------------------------------------------------------------------
// alu32 channel interfaces
// valid/ready request and response channels of the alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// request channel: operation and operands
interface alu32_req_if;
    logic                          valid;
    logic                          ready;
    logic [alu32_pkg::OP_W-1:0]    operation;
    logic [alu32_pkg::DATA_W-1:0]  operand_a;
    logic [alu32_pkg::DATA_W-1:0]  operand_b;

    modport source (output valid, output operation, output operand_a,
                    output operand_b, input ready);
    modport sink   (input valid, input operation, input operand_a,
                    input operand_b, output ready);
endinterface

// response channel: result and flags
interface alu32_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [alu32_pkg::DATA_W-1:0]  result_value;
    logic                          zero_flag;
    logic                          negative_flag;
    logic                          carry_flag;
    logic                          overflow_flag;

    modport source (output valid, output result_value, output zero_flag,
                    output negative_flag, output carry_flag,
                    output overflow_flag, input ready);
    modport sink   (input valid, input result_value, input zero_flag,
                    input negative_flag, input carry_flag,
                    input overflow_flag, output ready);
endinterface

// File: design/alu_with_flags_32bit_unit.sv
// ----------------------------------------------------------------------------
// alu_with_flags_32bit_unit
// 32-bit alu with zero, negative, carry and overflow flags
// path: a request passes the input reg and then the result reg before the response is valid
// throughput: 1 request per cycle unless the response stalls, set by the single-pass core between the regs
// a stalled response keeps one more request in the input register
// reset: synchronous active-low i_rst_n clears both stage valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alu_with_flags_32bit_unit_assert.svh"

module alu_with_flags_32bit_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    alu32_req_if.sink    i_req,
    alu32_rsp_if.source  o_rsp
);

    logic                         s1_ready;
    logic                         s2_ready;
    logic                         r_s1_valid;
    logic                         n_s1_valid;
    logic [alu32_pkg::OP_W-1:0]   r_s1_op;
    logic [alu32_pkg::DATA_W-1:0] r_s1_a;
    logic [alu32_pkg::DATA_W-1:0] r_s1_b;
    logic                         r_s2_valid;
    logic                         n_s2_valid;
    alu32_pkg::t_alu_result       r_s2_res;
    alu32_pkg::t_alu_result       core_res;

    // stage ready chain
    assign s2_ready    = !r_s2_valid || o_rsp.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_req.ready = s1_ready;

    // next valid bits
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s1_ready) begin
            n_s1_valid = i_req.valid;
        end
        n_s2_valid = r_s2_valid;
        if (s2_ready) begin
            n_s2_valid = r_s1_valid;
        end
    end

    // valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    // input register captures the request
    always_ff @(posedge i_clk) begin
        if (i_req.valid && s1_ready) begin
            r_s1_op <= i_req.operation;
            r_s1_a  <= i_req.operand_a;
            r_s1_b  <= i_req.operand_b;
        end
    end

    // alu datapath
    alu32_core u_core (
        .i_operation (r_s1_op),
        .i_operand_a (r_s1_a),
        .i_operand_b (r_s1_b),
        .o_result    (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s2_ready) begin
            r_s2_res <= core_res;
        end
    end

    // response outputs
    assign o_rsp.valid         = r_s2_valid;
    assign o_rsp.result_value  = r_s2_res.result_value;
    assign o_rsp.zero_flag     = r_s2_res.zero_flag;
    assign o_rsp.negative_flag = r_s2_res.negative_flag;
    assign o_rsp.carry_flag    = r_s2_res.carry_flag;
    assign o_rsp.overflow_flag = r_s2_res.overflow_flag;

    // assertions
    `ALU_ASSERT_NEXT(a_req_loads_s1, i_clk, i_rst_n, i_req.valid && s1_ready, r_s1_valid)
    `ALU_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !s2_ready, r_s1_valid && $stable(r_s1_op) && $stable(r_s1_a) && $stable(r_s1_b))
    `ALU_ASSERT_NEXT(a_drain, i_clk, i_rst_n, r_s2_valid && o_rsp.ready && !r_s1_valid, !r_s2_valid)
    `ALU_ASSERT_SAME(a_zero_flag, i_clk, i_rst_n, r_s2_valid, r_s2_res.zero_flag == (r_s2_res.result_value == '0))

endmodule

// File: design/alu32_core.sv
// ----------------------------------------------------------------------------
// alu32 core
// combinational datapath: arithmetic, logic, shifts, rotates and flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alu32_core (
    input  logic [alu32_pkg::OP_W-1:0]   i_operation,
    input  logic [alu32_pkg::DATA_W-1:0] i_operand_a,
    input  logic [alu32_pkg::DATA_W-1:0] i_operand_b,
    output alu32_pkg::t_alu_result       o_result
);

    logic [alu32_pkg::DATA_W-1:0]  addend;
    logic [alu32_pkg::DATA_W:0]    sum;
    logic                          carry_into_msb;
    logic [alu32_pkg::SHAMT_W-1:0] amount;
    logic [alu32_pkg::WIDE_W-1:0]  wide_left;
    logic [alu32_pkg::WIDE_W-1:0]  wide_right;
    logic                          out_left;
    logic                          out_right;
    logic [alu32_pkg::DATA_W-1:0]  res;
    logic                          cy;
    logic                          ov;

    // adder: subtract adds the two's complement of b
    always_comb begin
        addend = i_operand_b;
        if (alu32_pkg::t_alu_op'(i_operation) == alu32_pkg::OP_SUB) begin
            addend = ~i_operand_b + alu32_pkg::DATA_W'(1);
        end
        sum = {1'b0, i_operand_a} + {1'b0, addend};
        carry_into_msb = sum[alu32_pkg::DATA_W-1] ^ i_operand_a[alu32_pkg::DATA_W-1]
                         ^ addend[alu32_pkg::DATA_W-1];
    end

    // double-width shifter views; out-of-word bits give the carry
    always_comb begin
        amount     = i_operand_b[alu32_pkg::SHAMT_W-1:0];
        wide_left  = {{alu32_pkg::DATA_W{1'b0}}, i_operand_a} << amount;
        wide_right = {i_operand_a, {alu32_pkg::DATA_W{1'b0}}} >> amount;
        out_left   = |wide_left[alu32_pkg::WIDE_W-1:alu32_pkg::DATA_W];
        out_right  = |wide_right[alu32_pkg::DATA_W-1:0];
    end

    // operation select
    always_comb begin
        res = '0;
        cy  = 1'b0;
        ov  = 1'b0;
        case (alu32_pkg::t_alu_op'(i_operation))
            alu32_pkg::OP_ADD, alu32_pkg::OP_SUB: begin
                res = sum[alu32_pkg::DATA_W-1:0];
                cy  = sum[alu32_pkg::DATA_W];
                ov  = sum[alu32_pkg::DATA_W] ^ carry_into_msb;
            end
            alu32_pkg::OP_AND: res = i_operand_a & i_operand_b;
            alu32_pkg::OP_OR:  res = i_operand_a | i_operand_b;
            alu32_pkg::OP_XOR: res = i_operand_a ^ i_operand_b;
            alu32_pkg::OP_NOT: res = ~i_operand_a;
            alu32_pkg::OP_SHL: begin
                res = wide_left[alu32_pkg::DATA_W-1:0];
                cy  = out_left;
            end
            alu32_pkg::OP_SHR: begin
                res = wide_right[alu32_pkg::WIDE_W-1:alu32_pkg::DATA_W];
                cy  = out_right;
            end
            alu32_pkg::OP_ROL: begin
                res = wide_left[alu32_pkg::DATA_W-1:0]
                      | wide_left[alu32_pkg::WIDE_W-1:alu32_pkg::DATA_W];
                cy  = out_left;
            end
            alu32_pkg::OP_ROR: begin
                res = wide_right[alu32_pkg::DATA_W-1:0]
                      | wide_right[alu32_pkg::WIDE_W-1:alu32_pkg::DATA_W];
                cy  = out_right;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // flag bundle
    always_comb begin
        o_result.result_value  = res;
        o_result.zero_flag     = (res == '0);
        o_result.negative_flag = res[alu32_pkg::DATA_W-1];
        o_result.carry_flag    = cy;
        o_result.overflow_flag = ov;
    end

endmodule

// File: tb/alu32_flag_checker.sv
// ----------------------------------------------------------------------------
// alu32 flag checker
// watches the request and response channels of the 32-bit alu, predicts the
// result and nzcv flags of every accepted request and compares each accepted
// response, field by field, against the oldest pending prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alu32_flag_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    alu32_req_if  i_req,
    alu32_rsp_if  i_rsp,
    output int    o_mismatch_count,
    output int    o_outstanding
);
    import alu32_pkg::*;

    // cap on printed mismatch lines, counting goes on past it
    localparam int MAX_PRINTED = 100;

    t_alu_result pending_results[$];
    int          response_index;

    initial begin
        o_mismatch_count = 0;
        o_outstanding    = 0;
        response_index   = 0;
    end

    // result and flags of one operation
    function automatic t_alu_result predict_alu(input logic [OP_W-1:0]   op,
                                                input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
        t_alu_result         r;
        logic [DATA_W-1:0]   addend;
        logic [DATA_W-1:0]   res;
        logic [DATA_W-1:0]   low_sum;
        logic [SHAMT_W-1:0]  amt;
        logic [WIDE_W-1:0]   wide;
        logic                carry;
        logic                ovf;
        amt   = b[SHAMT_W-1:0];
        res   = '0;
        carry = 1'b0;
        ovf   = 1'b0;
        case (op)
            OP_ADD, OP_SUB: begin
                // subtract adds the two's complement of b
                addend  = (op == OP_SUB) ? (~b + 32'd1) : b;
                res     = a + addend;
                carry   = (res < a);
                low_sum = {1'b0, a[DATA_W-2:0]} + {1'b0, addend[DATA_W-2:0]};
                ovf     = carry ^ low_sum[DATA_W-1];
            end
            OP_AND: res = a & b;
            OP_OR:  res = a | b;
            OP_XOR: res = a ^ b;
            OP_NOT: res = ~a;
            OP_SHL: begin
                wide  = {{DATA_W{1'b0}}, a} << amt;
                res   = wide[DATA_W-1:0];
                carry = |wide[WIDE_W-1:DATA_W];
            end
            OP_SHR: begin
                wide  = {a, {DATA_W{1'b0}}} >> amt;
                res   = wide[WIDE_W-1:DATA_W];
                carry = |wide[DATA_W-1:0];
            end
            OP_ROL: begin
                wide  = {{DATA_W{1'b0}}, a} << amt;
                res   = wide[DATA_W-1:0] | wide[WIDE_W-1:DATA_W];
                carry = |wide[WIDE_W-1:DATA_W];
            end
            OP_ROR: begin
                wide  = {a, {DATA_W{1'b0}}} >> amt;
                res   = wide[DATA_W-1:0] | wide[WIDE_W-1:DATA_W];
                carry = |wide[DATA_W-1:0];
            end
            default: res = '0;
        endcase
        r.result_value  = res;
        r.zero_flag     = (res == '0);
        r.negative_flag = res[DATA_W-1];
        r.carry_flag    = carry;
        r.overflow_flag = ovf;
        return r;
    endfunction

    // one line per mismatch up to the print cap, then count it
    task automatic report_mismatch(input string detail);
        if (o_mismatch_count < MAX_PRINTED)
            $display("alu check: response %0d: %s", response_index, detail);
        o_mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // match responses to predictions, then record new requests
    always @(posedge i_clk) begin : track_proc
        t_alu_result want;
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("response with no request pending");
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_value", i_rsp.result_value, want.result_value);
                    check_field("zero_flag", i_rsp.zero_flag, want.zero_flag);
                    check_field("negative_flag", i_rsp.negative_flag, want.negative_flag);
                    check_field("carry_flag", i_rsp.carry_flag, want.carry_flag);
                    check_field("overflow_flag", i_rsp.overflow_flag, want.overflow_flag);
                end
                response_index++;
            end
            if (i_req.valid && i_req.ready)
                pending_results.push_back(predict_alu(i_req.operation, i_req.operand_a,
                                                      i_req.operand_b));
        end
        o_outstanding = pending_results.size();
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// alu_with_flags_32bit_unit testbench
// drives directed and random requests through the alu under several idle and
// stall patterns; the checker beside the block predicts and compares results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import alu32_pkg::*;

    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd10;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 4'd15;
    localparam int RANDOM_PER_PHASE = 175;
    localparam int MAX_GAP          = 16;
    localparam int DRAIN_CYCLES     = 8;
    localparam int RUN_LIMIT_NS     = 400000;

    logic i_clk;
    logic i_rst_n;
    int   mismatch_count;
    int   outstanding;
    int   sender_idle_pct;
    int   receiver_stall_pct;

    alu32_req_if req_ch ();
    alu32_rsp_if rsp_ch ();

    alu_with_flags_32bit_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    alu32_flag_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (req_ch),
        .i_rsp            (rsp_ch),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // response ready, stalls at the current rate
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // one request, called and returning at a falling edge
    task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] a,
                                input logic [DATA_W-1:0] b);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // hold off requests until every response is back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    // operand biased toward the word edges
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int count);
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        repeat (count) begin
            if ($urandom_range(99) < 8)
                op = OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
            else
                op = OP_W'($urandom_range(OP_ROR, OP_ADD));
            a = pick_operand();
            b = pick_operand();
            // equal operands give a zero difference
            if (op == OP_SUB && $urandom_range(9) == 0)
                b = a;
            // shift amounts with junk above the low five bits
            if (op inside {OP_SHL, OP_SHR, OP_ROL, OP_ROR}) begin
                b = $urandom;
                if ($urandom_range(3) == 0)
                    b[SHAMT_W-1:0] = $urandom_range(1) ? 5'd0 : 5'd31;
            end
            send_request(op, a, b);
        end
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_ADD;
        req_ch.operand_a   = '0;
        req_ch.operand_b   = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: edges of add and sub
        send_request(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001);
        send_request(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        send_request(OP_ADD, 32'h8000_0000, 32'h8000_0000);
        send_request(OP_ADD, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_SUB, 32'h1234_5678, 32'h0000_0000);
        send_request(OP_SUB, 32'h8000_0000, 32'h0000_0001);
        send_request(OP_SUB, 32'h0000_0005, 32'h0000_0007);
        // logic operations
        send_request(OP_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_request(OP_OR,  32'h0000_0000, 32'h0000_0000);
        send_request(OP_XOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_NOT, 32'h0000_0000, 32'h1111_1111);
        send_request(OP_NOT, 32'hFFFF_FFFF, 32'h0000_0000);
        // shifts and rotates: zero amount, full amount, upper bits of b set
        send_request(OP_SHL, 32'hDEAD_BEEF, 32'h0000_0000);
        send_request(OP_SHL, 32'hFFFF_FFFF, 32'h0000_001F);
        send_request(OP_SHL, 32'h8000_0001, 32'hFFFF_FFE1);
        send_request(OP_SHR, 32'hDEAD_BEEF, 32'hFFFF_FFE0);
        send_request(OP_SHR, 32'h0000_0001, 32'h0000_0001);
        send_request(OP_ROL, 32'h8000_0001, 32'h0000_0001);
        send_request(OP_ROL, 32'hFFFF_FFFF, 32'h0000_001F);
        send_request(OP_ROR, 32'h1234_5678, 32'h0000_0020);
        send_request(OP_ROR, 32'h0000_0001, 32'hF000_001F);
        // unused codes
        send_request(OP_FIRST_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_LAST_UNUSED, 32'h8000_0000, 32'h0000_0001);
        drain_responses();

        // random phases: no idling, sender idle, receiver stall, both
        run_random(RANDOM_PER_PHASE);
        drain_responses();
        sender_idle_pct = 49;
        run_random(RANDOM_PER_PHASE);
        sender_idle_pct    = 0;
        receiver_stall_pct = 49;
        run_random(RANDOM_PER_PHASE);
        sender_idle_pct    = 15;
        receiver_stall_pct = 15;
        run_random(RANDOM_PER_PHASE);

        // wait out the pipeline, then give the verdict
        drain_responses();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("alu_with_flags_32bit_unit regression: pass");
        else
            $display("alu_with_flags_32bit_unit regression: fail");
        $finish;
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("alu_with_flags_32bit_unit regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/alu32_pkg.sv
design/alu32_if.sv
design/alu32_core.sv
design/alu_with_flags_32bit_unit.sv
tb/alu32_flag_checker.sv
tb/tb.sv
